[design/dlr_pkg.sv]
`default_nettype none

package dlr_pkg;

  localparam int CoordBits = 6;
  localparam int FifoDepth = 2;
  localparam int FifoAw    = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

  typedef logic [CoordBits-1:0]        coord_t;
  typedef logic signed [CoordBits:0]   delta_t;
  typedef logic [FifoAw-1:0]           fifo_ptr_t;
  typedef logic [FifoAw:0]             fifo_cnt_t;

  // one line as the walker needs it
  typedef struct packed {
    coord_t x;
    coord_t y;
    delta_t dx;
    delta_t dy;
    coord_t span;
  } line_desc_t;

  typedef struct packed {
    coord_t coord;
    coord_t rem;
  } axis_t;

  typedef enum logic {
    WalkIdle,
    WalkRun
  } walk_state_e;

  // one dda step on one axis: remainder kept in [0, span), or 0 when span is 0
  function automatic axis_t axis_step(coord_t c, coord_t r, delta_t d, coord_t span);
    logic signed [CoordBits+1:0] sum;
    logic signed [CoordBits+1:0] span_s;
    logic signed [CoordBits+1:0] adj;
    axis_t res;
    sum    = $signed({2'b00, r}) + $signed({d[CoordBits], d});
    span_s = $signed({2'b00, span});
    res.coord = c;
    res.rem   = sum[CoordBits-1:0];
    adj       = sum;
    if (d[CoordBits]) begin
      if (sum < 0) begin
        adj       = sum + span_s;
        res.rem   = adj[CoordBits-1:0];
        res.coord = c - coord_t'(1);
      end
    end else if (sum >= span_s) begin
      adj       = sum - span_s;
      res.rem   = adj[CoordBits-1:0];
      res.coord = c + coord_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/dlr_front.sv]
`default_nettype none

module dlr_front import dlr_pkg::*; (
  input  wire coord_t     start_x_i,
  input  wire coord_t     start_y_i,
  input  wire coord_t     end_x_i,
  input  wire coord_t     end_y_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            push_o,
  output line_desc_t      push_desc_o,
  input  wire logic       fifo_full_i
);

  delta_t dx;
  delta_t dy;
  delta_t adx;
  delta_t ady;

  always_comb begin
    dx  = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy  = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    adx = dx[CoordBits] ? -dx : dx;
    ady = dy[CoordBits] ? -dy : dy;
  end

  always_comb begin
    push_desc_o.x    = start_x_i;
    push_desc_o.y    = start_y_i;
    push_desc_o.dx   = dx;
    push_desc_o.dy   = dy;
    // major axis length, at most 2^CoordBits - 1
    push_desc_o.span = (adx > ady) ? adx[CoordBits-1:0] : ady[CoordBits-1:0];
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

`default_nettype wire

[design/dlr_fifo.sv]
`default_nettype none

module dlr_fifo import dlr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire line_desc_t push_desc_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output line_desc_t      pop_desc_o,
  output logic            valid_o
);

  line_desc_t mem_q [FifoDepth];
  fifo_ptr_t  wr_ptr_q, wr_ptr_d;
  fifo_ptr_t  rd_ptr_q, rd_ptr_d;
  fifo_cnt_t  cnt_q, cnt_d;

  assign full_o     = (cnt_q == fifo_cnt_t'(FifoDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_desc_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + fifo_ptr_t'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + fifo_ptr_t'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + fifo_cnt_t'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - fifo_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fifo_cnt_t'(FifoDepth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[design/dlr_back.sv]
`default_nettype none

module dlr_back import dlr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       desc_valid_i,
  input  wire line_desc_t desc_i,
  output logic            pop_o,
  output coord_t          pixel_x_o,
  output coord_t          pixel_y_o,
  output logic            last_pixel_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i
);

  walk_state_e state_q, state_d;
  coord_t      x_q, x_d;
  coord_t      y_q, y_d;
  coord_t      rx_q, rx_d;
  coord_t      ry_q, ry_d;
  delta_t      dx_q, dx_d;
  delta_t      dy_q, dy_d;
  coord_t      span_q, span_d;
  coord_t      cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  coord_t      px_q, px_d;
  coord_t      py_q, py_d;
  logic        last_q, last_d;
  logic        load;
  axis_t       step_x;
  axis_t       step_y;

  // output register free or being drained this cycle
  assign load   = !out_valid_q || !out_stall_i;
  assign step_x = axis_step(x_q, rx_q, dx_q, span_q);
  assign step_y = axis_step(y_q, ry_q, dy_q, span_q);

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    x_d         = x_q;
    y_d         = y_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    span_d      = span_q;
    cnt_d       = cnt_q;
    out_valid_d = load ? 1'b0 : out_valid_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    case (state_q)
      WalkIdle: begin
        if (desc_valid_i) begin
          pop_o   = 1'b1;
          x_d     = desc_i.x;
          y_d     = desc_i.y;
          rx_d    = '0;
          ry_d    = '0;
          dx_d    = desc_i.dx;
          dy_d    = desc_i.dy;
          span_d  = desc_i.span;
          cnt_d   = desc_i.span;
          state_d = WalkRun;
        end
      end
      WalkRun: begin
        if (load) begin
          out_valid_d = 1'b1;
          px_d        = x_q;
          py_d        = y_q;
          last_d      = (cnt_q == '0);
          x_d         = step_x.coord;
          rx_d        = step_x.rem;
          y_d         = step_y.coord;
          ry_d        = step_y.rem;
          cnt_d       = cnt_q - coord_t'(1);
          if (cnt_q == '0) begin
            state_d = WalkIdle;
          end
        end
      end
      default: begin
        state_d = WalkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WalkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    span_q <= span_d;
    cnt_q  <= cnt_d;
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WalkRun |-> (rx_q < span_q) || (rx_q == '0))
    else $error("x remainder out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WalkRun |-> (ry_q < span_q) || (ry_q == '0))
    else $error("y remainder out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WalkRun && load && cnt_q == '0 |=> state_q == WalkIdle && out_valid_q && last_q)
    else $error("walk did not end on the last pixel");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == WalkIdle)
    else $error("line taken while walking");

endmodule

`default_nettype wire

[design/dda_line_rasterizer.sv]
// a line passes the line queue, the walker registers and the pixel output register
// the walker emits s + 1 pixels for a line of span s (larger of |dx|, |dy|),
//   one pixel a cycle while out_stall_i is low, and loads a line only when idle
// a 2-entry line queue lets new lines in while the walker is busy
// reset: rst_ni asynchronous active low, clears queue, walker state and output valid
`default_nettype none

module dda_line_rasterizer import dlr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire coord_t start_x_i,
  input  wire coord_t start_y_i,
  input  wire coord_t end_x_i,
  input  wire coord_t end_y_i,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  output coord_t      pixel_x_o,
  output coord_t      pixel_y_o,
  output logic        last_pixel_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i
);

  logic       push;
  line_desc_t push_desc;
  logic       fifo_full;
  logic       pop;
  line_desc_t pop_desc;
  logic       fifo_valid;

  dlr_front u_front (
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_desc_o (push_desc),
    .fifo_full_i (fifo_full)
  );

  dlr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc),
    .valid_o     (fifo_valid)
  );

  dlr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (fifo_valid),
    .desc_i       (pop_desc),
    .pop_o        (pop),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

`default_nettype wire
